>>> sv/mbrc_pkg.sv
// shared types, constants and the crc helper for the modbus rtu reply checker
`default_nettype none

package mbrc_pkg;

  // verdict codes carried on out_status
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_INCOMPLETE  = 3'd1,
    ST_ADDRESS     = 3'd2,
    ST_FUNCTION    = 3'd3,
    ST_EXC_CRC     = 3'd4,
    ST_CRC         = 3'd5,
    ST_CRC_EXTRA   = 3'd6,
    ST_EXCEPTION   = 3'd7
  } status_t;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_DEVICE   = 2'd0,
    REG_FUNCTION = 2'd1,
    REG_LENGTH   = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  localparam int unsigned ADDR_W = 4;

  localparam logic [7:0]  DEVICE_RST   = 8'd1;
  localparam logic [6:0]  FUNCTION_RST = 7'd3;
  localparam logic [7:0]  LENGTH_RST   = 8'd9;
  localparam logic [7:0]  LENGTH_MIN   = 8'd5;
  localparam logic [7:0]  COUNT_MAX    = 8'hFF;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  EXC_BIT      = 8'h80;
  localparam logic [7:0]  FUNC_MASK    = 8'h7F;

  // byte-wide modbus crc-16 update, reflected polynomial
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/modbus_rtu_reply_checker.sv
// modbus rtu reply checker: byte-wise capture, crc and verdict
`default_nettype none

// channel   direction  ports                                       handshake
// ------    ---------  ------------------------------------------  -----------------
// in        input      in_rx_byte[7:0], in_is_last                 in_valid / in_stall
// out       output     out_status[2:0], out_exception_code[7:0],   out_valid / out_stall
//                      out_data_word[31:0]
// cfg       input      psel, penable, pwrite, paddr[3:0], pwdata,  apb, pready high
//                      prdata
//
// every item passes through the input register, then through the crc and verdict logic;
// a new item is taken every cycle unless in_stall holds the input
// a last item is held in the input register and its verdict then in the result register,
// which raises out_valid
// in_stall rises only when a last item waits and the result register is full and stalled
// rst_n is synchronous and restores register defaults and an empty frame

module modbus_rtu_reply_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // received byte channel
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [7:0]                  in_rx_byte,
  input  wire logic                        in_is_last,
  // verdict channel
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [2:0]                  out_status,
  output      logic [7:0]                  out_exception_code,
  output      logic [31:0]                 out_data_word,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mbrc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);

  // configuration registers
  logic [7:0] exp_device_r;
  logic [6:0] exp_function_r;
  logic [7:0] reply_length_r;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // frame state
  logic [7:0]  byte_count_r,      byte_count_nxt;
  logic [15:0] running_crc_r,     running_crc_nxt;
  logic [15:0] crc_after_three_r, crc_after_three_nxt;
  logic [15:0] crc_before_tail_r, crc_before_tail_nxt;
  logic [15:0] received_tail_r,   received_tail_nxt;
  logic [7:0]  address_byte_r,    address_byte_nxt;
  logic [7:0]  function_byte_r,   function_byte_nxt;
  logic [7:0]  third_byte_r,      third_byte_nxt;
  logic [31:0] payload_bytes_r,   payload_bytes_nxt;

  // result register
  logic                  out_valid_r;
  mbrc_pkg::status_t     status_r,   status_nxt;
  logic [7:0]            exc_code_r, exc_code_nxt;
  logic [31:0]           word_r,     word_nxt;

  logic       cfg_wr;
  mbrc_pkg::reg_idx_t cfg_idx;
  logic       out_free;
  logic       proceed;
  logic [7:0] len;
  logic [7:0] pos;
  logic [7:0] byt0, byt1, byt2, byt3;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = mbrc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_device_r   <= mbrc_pkg::DEVICE_RST;
      exp_function_r <= mbrc_pkg::FUNCTION_RST;
      reply_length_r <= mbrc_pkg::LENGTH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mbrc_pkg::REG_DEVICE:   exp_device_r   <= pwdata[7:0];
        mbrc_pkg::REG_FUNCTION: exp_function_r <= pwdata[6:0];
        mbrc_pkg::REG_LENGTH:   reply_length_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mbrc_pkg::REG_DEVICE:   prdata = {24'd0, exp_device_r};
      mbrc_pkg::REG_FUNCTION: prdata = {25'd0, exp_function_r};
      mbrc_pkg::REG_LENGTH:   prdata = {24'd0, reply_length_r};
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------- flow control ----------------
  // a byte that is not last never needs the result register
  assign out_free = !out_valid_r || !out_stall;
  assign proceed  = in_valid_r && (!in_last_r || out_free);
  assign in_stall = in_valid_r && !proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (proceed) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
      in_last_r <= in_is_last;
    end
  end

  // ---------------- capture, crc and verdict ----------------
  // lengths below the minimum behave as the minimum
  assign len = (reply_length_r < mbrc_pkg::LENGTH_MIN) ? mbrc_pkg::LENGTH_MIN
                                                        : reply_length_r;
  assign pos = byte_count_r;

  always_comb begin
    byte_count_nxt      = byte_count_r;
    crc_after_three_nxt = crc_after_three_r;
    crc_before_tail_nxt = crc_before_tail_r;
    received_tail_nxt   = received_tail_r;
    address_byte_nxt    = address_byte_r;
    function_byte_nxt   = function_byte_r;
    third_byte_nxt      = third_byte_r;
    payload_bytes_nxt   = payload_bytes_r;

    // saturated count: crc still runs, nothing else is captured
    if (pos != mbrc_pkg::COUNT_MAX) begin
      if (pos == len - 8'd2) begin
        crc_before_tail_nxt = running_crc_r;
      end
      case (pos)
        8'd0: address_byte_nxt = in_byte_r;
        8'd1: function_byte_nxt = in_byte_r;
        8'd2: third_byte_nxt = in_byte_r;
        8'd3: payload_bytes_nxt[7:0]   = in_byte_r;
        8'd4: payload_bytes_nxt[15:8]  = in_byte_r;
        8'd5: payload_bytes_nxt[23:16] = in_byte_r;
        8'd6: payload_bytes_nxt[31:24] = in_byte_r;
        default: ;
      endcase
      if (pos == len - 8'd2) begin
        received_tail_nxt[7:0] = in_byte_r;
      end else if (pos == len - 8'd1) begin
        received_tail_nxt[15:8] = in_byte_r;
      end
      byte_count_nxt = pos + 8'd1;
    end
    running_crc_nxt = mbrc_pkg::crc_update(running_crc_r, in_byte_r);
    if (pos == 8'd2) begin
      crc_after_three_nxt = running_crc_nxt;
    end
  end

  // payload bytes that fall on the crc tail read as zero
  assign byt0 = (len > 8'd5) ? payload_bytes_nxt[7:0]   : 8'd0;
  assign byt1 = (len > 8'd6) ? payload_bytes_nxt[15:8]  : 8'd0;
  assign byt2 = (len > 8'd7) ? payload_bytes_nxt[23:16] : 8'd0;
  assign byt3 = (len > 8'd8) ? payload_bytes_nxt[31:24] : 8'd0;

  // verdict priority: short, address, function, exception, crc, ok
  always_comb begin
    exc_code_nxt = 8'd0;
    word_nxt     = 32'd0;
    if (byte_count_nxt < mbrc_pkg::LENGTH_MIN ||
        (!function_byte_nxt[7] && byte_count_nxt < len)) begin
      status_nxt = mbrc_pkg::ST_INCOMPLETE;
    end else if (address_byte_nxt != exp_device_r) begin
      status_nxt = mbrc_pkg::ST_ADDRESS;
    end else if ((function_byte_nxt & mbrc_pkg::FUNC_MASK) != {1'b0, exp_function_r}) begin
      status_nxt = mbrc_pkg::ST_FUNCTION;
    end else if ((function_byte_nxt & mbrc_pkg::EXC_BIT) != 8'd0) begin
      // exception reply: crc over three bytes sits in the fourth and fifth bytes
      if (payload_bytes_nxt[15:0] == crc_after_three_nxt) begin
        status_nxt   = mbrc_pkg::ST_EXCEPTION;
        exc_code_nxt = third_byte_nxt;
      end else begin
        status_nxt = mbrc_pkg::ST_EXC_CRC;
      end
    end else if (received_tail_nxt != crc_before_tail_nxt) begin
      status_nxt = (byte_count_nxt > len) ? mbrc_pkg::ST_CRC_EXTRA : mbrc_pkg::ST_CRC;
    end else begin
      status_nxt = mbrc_pkg::ST_OK;
      word_nxt   = {byt2, byt3, byt0, byt1};
    end
  end

  // frame state: a last byte returns everything to the empty frame
  always_ff @(posedge clk) begin
    if (!rst_n || (proceed && in_last_r)) begin
      byte_count_r      <= 8'd0;
      running_crc_r     <= mbrc_pkg::CRC_INIT;
      crc_after_three_r <= 16'd0;
      crc_before_tail_r <= 16'd0;
      received_tail_r   <= 16'd0;
      address_byte_r    <= 8'd0;
      function_byte_r   <= 8'd0;
      third_byte_r      <= 8'd0;
      payload_bytes_r   <= 32'd0;
    end else if (proceed) begin
      byte_count_r      <= byte_count_nxt;
      running_crc_r     <= running_crc_nxt;
      crc_after_three_r <= crc_after_three_nxt;
      crc_before_tail_r <= crc_before_tail_nxt;
      received_tail_r   <= received_tail_nxt;
      address_byte_r    <= address_byte_nxt;
      function_byte_r   <= function_byte_nxt;
      third_byte_r      <= third_byte_nxt;
      payload_bytes_r   <= payload_bytes_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && in_last_r) begin
      status_r   <= status_nxt;
      exc_code_r <= exc_code_nxt;
      word_r     <= word_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_exception_code = exc_code_r;
  assign out_data_word      = word_r;

  // ---------------- assertions ----------------
  a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && in_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked verdict");

  a_frame_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (proceed && in_last_r) |=> (byte_count_r == 8'd0 &&
                                running_crc_r == mbrc_pkg::CRC_INIT))
    else $error("frame state not cleared after last byte");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (proceed && !in_last_r && byte_count_r != mbrc_pkg::COUNT_MAX)
      |=> byte_count_r == $past(byte_count_r) + 8'd1)
    else $error("byte count did not advance");

  a_code_only_on_exception: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != mbrc_pkg::ST_EXCEPTION) |-> exc_code_r == 8'd0)
    else $error("exception code on a non-exception verdict");

  a_word_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != mbrc_pkg::ST_OK) |-> word_r == 32'd0)
    else $error("data word on a failed verdict");

endmodule

`default_nettype wire
